[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clock; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define LSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every edge, reset included
`define LSR_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LSR_ASSERT(lbl, prop, msg)
`define LSR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/core/lsr_pkg.sv]
// ----------------------------------------------------------------------------
// LFU slot replacement package
// Sizes, outcome codes and the structs shared by controller, datapath and top.
// ----------------------------------------------------------------------------
package lsr_pkg;

   localparam int SLOTS     = 16;
   localparam int ID_BITS   = 7;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TREE_N    = 1 << SLOT_BITS;
   localparam int MID_LVLS  = SLOT_BITS / 2;
   localparam int REST_LVLS = SLOT_BITS - MID_LVLS;
   localparam int MID_N     = TREE_N >> MID_LVLS;

   localparam int HITS_W    = 16;
   localparam int STAMP_W   = 32;

   // port field widths
   localparam int ITEM_ID_W = 7;
   localparam int OUTCOME_W = 2;
   localparam int SLOT_W    = 4;
   localparam int CSR_W     = 5;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(16);

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT     = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL    = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACE = 2'd2;

   typedef struct packed {
      logic load;    // capture request id
      logic scan;    // match, free search, first half of victim tree
      logic commit;  // finish victim pick, update slots, emit response
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [SLOT_W-1:0]    slot_used;
      logic                 evicted_valid;
      logic [ITEM_ID_W-1:0] evicted_id;
      logic [HITS_W-1:0]    hit_count;
   } result_type;

endpackage

[rtl/core/lfu_slot_replacement.sv]
// ----------------------------------------------------------------------------
// LFU slot replacement
// Top level: CSR, active slot mask, controller, datapath, response register.
// ----------------------------------------------------------------------------
// Each request names an identifier. A hit bumps the slot's count (saturating);
// a miss fills the lowest free active slot, or else evicts the active slot
// with the lowest count, oldest arrival breaking ties, and reports it. A
// request passes through a scan cycle (match, free search and the lower
// half of the min-count/oldest tree, registered) and an update cycle (upper
// half of the tree, slot write, response load). With the response register
// free, a new request is taken in the update cycle, overlapping the previous
// request's commit. A response held by rsp_ready stalls the update cycle only.
// csr_active_slots is taken any cycle; write it only with no request in
// flight. Zero acts as one, values above the slot count act as all slots.
// ----------------------------------------------------------------------------
module lfu_slot_replacement (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lsr_pkg::CSR_W-1:0]      csr_active_slots,
   // request
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lsr_pkg::ITEM_ID_W-1:0]  req_item_id,
   // response
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lsr_pkg::OUTCOME_W-1:0]  rsp_outcome,
   output logic [lsr_pkg::SLOT_W-1:0]     rsp_slot_used,
   output logic                           rsp_evicted_valid,
   output logic [lsr_pkg::ITEM_ID_W-1:0]  rsp_evicted_id,
   output logic [lsr_pkg::HITS_W-1:0]     rsp_hit_count
);
   import lsr_pkg::*;

   // active slot count register
   logic [CSR_W-1:0] csr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_valid) begin
         csr_ff <= csr_active_slots;
      end
   end

   // slot 0 is always live; counts past SLOTS simply light every slot
   logic [SLOTS-1:0] active;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         active[i] = (i == 0) || (32'(i) < 32'(csr_ff));
      end
   end

   // response register
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       out_free;
   ctrl_cmd_type cmd;

   assign out_free = !rsp_valid_ff || rsp_ready;

   lsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   lsr_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .active  (active),
      .item_id (req_item_id),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_ff.outcome;
   assign rsp_slot_used     = rsp_ff.slot_used;
   assign rsp_evicted_valid = rsp_ff.evicted_valid;
   assign rsp_evicted_id    = rsp_ff.evicted_id;
   assign rsp_hit_count     = rsp_ff.hit_count;

endmodule

[rtl/core/lsr_ctrl.sv]
// ----------------------------------------------------------------------------
// LFU slot replacement controller
// Sequences load, scan and commit for each request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  out_free,
   output lsr_pkg::ctrl_cmd_type cmd
);
   import lsr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LSR_ASSERT_RST(a_reset_idle, reset |=> state_ff == S_IDLE, "not idle after reset")
   `LSR_ASSERT(a_commit_free, cmd.commit |-> out_free, "commit into a full output stage")
   `LSR_ASSERT(a_scan_follows, cmd.load |=> cmd.scan, "load not followed by scan")

endmodule

[rtl/core/lsr_datapath.sv]
// ----------------------------------------------------------------------------
// LFU slot replacement datapath
// Slot storage, match and free search, two-stage victim tree, slot update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lsr_pkg::ctrl_cmd_type          cmd,
   input  logic [lsr_pkg::SLOTS-1:0]      active,
   input  logic [lsr_pkg::ITEM_ID_W-1:0]  item_id,
   output lsr_pkg::result_type            result
);
   import lsr_pkg::*;

   typedef struct packed {
      logic                 act;
      logic [SLOT_BITS-1:0] idx;
      logic [HITS_W-1:0]    hits;
      logic [STAMP_W-1:0]   stamp;
   } node_type;

   // right side wins only when strictly better: ties stay with the lower slot
   function automatic node_type pick(node_type a, node_type b);
      logic better;
      better = b.act && (!a.act || (b.hits < a.hits) ||
                         ((b.hits == a.hits) && (b.stamp < a.stamp)));
      return better ? b : a;
   endfunction

   // slot storage
   logic [SLOTS-1:0]   valid_ff;
   logic [ID_BITS-1:0] ident_ff [SLOTS];
   logic [HITS_W-1:0]  hits_ff  [SLOTS];
   logic [STAMP_W-1:0] stamp_ff [SLOTS];
   logic [STAMP_W-1:0] clock_ff;

   logic [ID_BITS-1:0] id_ff;

   // scan stage registers
   logic                 hit_ff, free_ff;
   logic [SLOT_BITS-1:0] hit_slot_ff, free_slot_ff;
   node_type             mid_ff [MID_N];

   // scan stage logic
   logic                 hit_found, free_found;
   logic [SLOT_BITS-1:0] hit_slot, free_slot;
   node_type             lo_tree [MID_LVLS+1][TREE_N];
   node_type             hi_tree [REST_LVLS+1][MID_N];
   node_type             victim;

   logic [ID_BITS+ITEM_ID_W-1:0] id_ext;
   assign id_ext = {{ID_BITS{1'b0}}, item_id};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= id_ext[ID_BITS-1:0];
      end
   end

   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_slot   = '0;
      free_slot  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (active[i] && valid_ff[i] && (ident_ff[i] == id_ff)) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_BITS'(i);
         end
         if (active[i] && !valid_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_BITS'(i);
         end
      end
   end

   // lower levels of the victim tree, registered at the end of scan
   always_comb begin
      for (int l = 0; l <= MID_LVLS; l++) begin
         for (int k = 0; k < TREE_N; k++) begin
            lo_tree[l][k] = '0;
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         lo_tree[0][k].act   = active[k];
         lo_tree[0][k].idx   = SLOT_BITS'(k);
         lo_tree[0][k].hits  = hits_ff[k];
         lo_tree[0][k].stamp = stamp_ff[k];
      end
      for (int l = 0; l < MID_LVLS; l++) begin
         for (int k = 0; k < TREE_N / 2; k++) begin
            if (k < (TREE_N >> (l + 1))) begin
               lo_tree[l+1][k] = pick(lo_tree[l][2*k], lo_tree[l][2*k+1]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         hit_ff       <= hit_found;
         hit_slot_ff  <= hit_slot;
         free_ff      <= free_found;
         free_slot_ff <= free_slot;
         for (int k = 0; k < MID_N; k++) begin
            mid_ff[k] <= lo_tree[MID_LVLS][k];
         end
      end
   end

   // upper levels of the victim tree
   always_comb begin
      for (int l = 0; l <= REST_LVLS; l++) begin
         for (int k = 0; k < MID_N; k++) begin
            hi_tree[l][k] = '0;
         end
      end
      for (int k = 0; k < MID_N; k++) begin
         hi_tree[0][k] = mid_ff[k];
      end
      for (int l = 0; l < REST_LVLS; l++) begin
         for (int k = 0; k < MID_N; k++) begin
            if (2 * k + 1 < (MID_N >> l)) begin
               hi_tree[l+1][k] = pick(hi_tree[l][2*k], hi_tree[l][2*k+1]);
            end
         end
      end
      victim = hi_tree[REST_LVLS][0];
   end

   // update stage
   logic [SLOT_BITS-1:0]       sel;
   logic [HITS_W-1:0]          new_hits;
   logic [SLOT_BITS+SLOT_W-1:0] sel_ext;
   logic [ID_BITS+ITEM_ID_W-1:0] ev_ext;

   always_comb begin
      if (hit_ff) begin
         sel = hit_slot_ff;
      end else if (free_ff) begin
         sel = free_slot_ff;
      end else begin
         sel = victim.idx;
      end
      if (hit_ff) begin
         new_hits = (hits_ff[sel] == '1) ? hits_ff[sel] : hits_ff[sel] + HITS_W'(1);
      end else begin
         new_hits = HITS_W'(1);
      end
      sel_ext = {{SLOT_W{1'b0}}, sel};
      ev_ext  = {{ITEM_ID_W{1'b0}}, ident_ff[sel]};

      result.slot_used = sel_ext[SLOT_W-1:0];
      result.hit_count = new_hits;
      if (hit_ff) begin
         result.outcome       = OUTCOME_HIT;
         result.evicted_valid = 1'b0;
         result.evicted_id    = '0;
      end else if (free_ff) begin
         result.outcome       = OUTCOME_FILL;
         result.evicted_valid = 1'b0;
         result.evicted_id    = '0;
      end else begin
         result.outcome       = OUTCOME_REPLACE;
         result.evicted_valid = 1'b1;
         result.evicted_id    = ev_ext[ITEM_ID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         clock_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[sel] <= 1'b1;
         clock_ff      <= clock_ff + STAMP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hits_ff[sel] <= new_hits;
         if (!hit_ff) begin
            ident_ff[sel] <= id_ff;
            stamp_ff[sel] <= clock_ff;
         end
      end
   end

   `LSR_ASSERT(a_clock_step, cmd.commit |=> clock_ff == $past(clock_ff) + STAMP_W'(1), "stamp clock skipped")
   `LSR_ASSERT(a_hit_live, cmd.commit && hit_ff |-> valid_ff[hit_slot_ff] && active[hit_slot_ff], "hit on dead slot")
   `LSR_ASSERT(a_victim_live, cmd.commit && !hit_ff && !free_ff |-> victim.act && valid_ff[victim.idx], "victim not a live slot")

endmodule
